[hw/rtl/battery_charge_level_monitor_top_assert.svh]
// ----------------------------------------------------------------------------
// Battery charge level monitor assertion macros
// Shorthand for clocked implication checks with the synchronous reset masked.
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_LEVEL_MONITOR_TOP_ASSERT_SVH
`define BATTERY_CHARGE_LEVEL_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication
`define BCLM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BCLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bclm_pkg.sv]
// ----------------------------------------------------------------------------
// Battery charge level monitor package
// Widths, codes, register defaults and the sequencer program ROM.
// ----------------------------------------------------------------------------
package bclm_pkg;

    // Stream and config widths
    localparam int SAMPLE_W  = 12;
    localparam int RATIO_W   = 12;
    localparam int MV_W      = 16;
    localparam int PCT_W     = 7;
    localparam int KIND_W    = 3;
    localparam int S_TDATA_W = 16;   // sample_mv, charger_pin, pad
    localparam int M_TDATA_W = 24;   // battery_mv, level_percent, pad
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int PC_W      = 4;
    localparam int PROD_W    = SAMPLE_W + RATIO_W;
    localparam int DIVW      = MV_W + PCT_W;   // width of num * 100
    localparam int QCNT_W    = 3;              // quotient bit index

    // Arithmetic constants
    localparam logic [MV_W-1:0]  JUMP_MV        = 16'd400;
    localparam logic [MV_W-1:0]  FULL_MARGIN_MV = 16'd700;
    localparam logic [PCT_W-1:0] PCT_FULL       = 7'd100;
    localparam logic [QCNT_W-1:0] QBIT_TOP      = 3'd6;

    // Register defaults
    localparam logic               RST_USE_PIN = 1'b0;
    localparam logic [RATIO_W-1:0] RST_RATIO   = 12'd512;
    localparam logic [MV_W-1:0]    RST_EMPTY   = 16'd3000;
    localparam logic [MV_W-1:0]    RST_FULL    = 16'd4200;
    localparam logic [PCT_W-1:0]   RST_LOW_PCT = 7'd20;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_PIN = 3'd0,
        CFG_RATIO   = 3'd1,
        CFG_EMPTY   = 3'd2,
        CFG_FULL    = 3'd3,
        CFG_LOW_PCT = 3'd4
    } t_cfg_idx;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_BEGIN  = 3'd0,
        KIND_STOP   = 3'd1,
        KIND_REPORT = 3'd2,
        KIND_LOW    = 3'd3,
        KIND_FULL   = 3'd4
    } t_kind;

    // Datapath operations
    typedef enum logic [3:0] {
        UOP_LOAD      = 4'd0,
        UOP_SCALE     = 4'd1,
        UOP_CHARGE    = 4'd2,
        UOP_PREP      = 4'd3,
        UOP_DIV       = 4'd4,
        UOP_FINISH    = 4'd5,
        UOP_EMIT_CHG  = 4'd6,
        UOP_EMIT_RPT  = 4'd7,
        UOP_EMIT_LOW  = 4'd8,
        UOP_EMIT_FULL = 4'd9
    } t_uop;

    // Sequencing: advance at once, or hold on a condition
    typedef enum logic [1:0] {
        SEQ_STEP     = 2'd0,
        SEQ_WAIT_IN  = 2'd1,
        SEQ_LOOP     = 2'd2,
        SEQ_WAIT_OUT = 2'd3
    } t_seq;

    typedef struct packed {
        t_uop            op;
        t_seq            seq;
        logic [PC_W-1:0] adv;
    } t_uword;

    typedef struct packed {
        logic in_take;
        logic emit_go;
        logic emit_skip;
        logic cnt_zero;
    } t_dp_status;

    // Program ROM
    function automatic t_uword ucode_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            4'd0:    w = '{op: UOP_LOAD,      seq: SEQ_WAIT_IN,  adv: 4'd1};
            4'd1:    w = '{op: UOP_SCALE,     seq: SEQ_STEP,     adv: 4'd2};
            4'd2:    w = '{op: UOP_CHARGE,    seq: SEQ_STEP,     adv: 4'd3};
            4'd3:    w = '{op: UOP_PREP,      seq: SEQ_STEP,     adv: 4'd4};
            4'd4:    w = '{op: UOP_DIV,       seq: SEQ_LOOP,     adv: 4'd5};
            4'd5:    w = '{op: UOP_FINISH,    seq: SEQ_STEP,     adv: 4'd6};
            4'd6:    w = '{op: UOP_EMIT_CHG,  seq: SEQ_WAIT_OUT, adv: 4'd7};
            4'd7:    w = '{op: UOP_EMIT_RPT,  seq: SEQ_WAIT_OUT, adv: 4'd8};
            4'd8:    w = '{op: UOP_EMIT_LOW,  seq: SEQ_WAIT_OUT, adv: 4'd9};
            4'd9:    w = '{op: UOP_EMIT_FULL, seq: SEQ_WAIT_OUT, adv: 4'd0};
            default: w = '{op: UOP_LOAD,      seq: SEQ_STEP,     adv: 4'd0};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/bclm_seq.sv]
// ----------------------------------------------------------------------------
// Battery charge level monitor sequencer
// Step counter over the program ROM with hold-or-advance jumps.
// ----------------------------------------------------------------------------
module bclm_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bclm_pkg::t_dp_status i_status,
    output bclm_pkg::t_uword     o_uword
);
    import bclm_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          w_uw;

    // Fetch the control word
    assign w_uw    = ucode_rom(r_pc);
    assign o_uword = w_uw;

    // Pick the next step
    always_comb begin
        n_pc = r_pc;
        unique case (w_uw.seq)
            SEQ_STEP:     n_pc = w_uw.adv;
            SEQ_WAIT_IN:  if (i_status.in_take) n_pc = w_uw.adv;
            SEQ_LOOP:     if (i_status.cnt_zero) n_pc = w_uw.adv;
            SEQ_WAIT_OUT: if (i_status.emit_go || i_status.emit_skip) n_pc = w_uw.adv;
            default:      n_pc = w_uw.adv;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

[hw/rtl/bclm_dp.sv]
// ----------------------------------------------------------------------------
// Battery charge level monitor datapath
// Config registers, voltage scaling, charge tracking, percentage divider and
// the result output register, each step driven by the control word.
// ----------------------------------------------------------------------------
module bclm_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bclm_pkg::t_uword                 i_uword,
    output bclm_pkg::t_dp_status             o_status,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [bclm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [bclm_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic [bclm_pkg::KIND_W-1:0]      o_m_tuser,
    output logic                             o_m_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bclm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bclm_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import bclm_pkg::*;

    // Configuration
    logic               r_use_pin;
    logic [RATIO_W-1:0] r_ratio;
    logic [MV_W-1:0]    r_empty;
    logic [MV_W-1:0]    r_full_mv;
    logic [PCT_W-1:0]   r_low_pct;

    // Sample and persistent state
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_pin;
    logic [MV_W-1:0]     r_bat;
    logic                r_started;
    logic                r_charging;
    logic                r_prev_pin;
    logic [MV_W-1:0]     r_prev_bat;

    // Per-sample work registers
    logic             r_chg_ev;
    logic             r_chg_stop;
    logic [MV_W-1:0]  r_chg_mv;
    logic             r_zero;
    logic             r_sat;
    logic [MV_W-1:0]  r_num;
    logic [MV_W-1:0]  r_den;
    logic [DIVW-1:0]  r_dvd;
    logic [DIVW-1:0]  r_rem;
    logic [DIVW-1:0]  r_lprod;
    logic [PCT_W-1:0] r_quo;
    logic [QCNT_W-1:0] r_cnt;
    logic [PCT_W-1:0] r_pct;
    logic             r_low;
    logic             r_full;

    // Output register
    logic             r_ovalid;
    t_kind            r_okind;
    logic [MV_W-1:0]  r_omv;
    logic [PCT_W-1:0] r_opct;
    logic             r_olast;

    logic [PROD_W-1:0] w_prod;
    logic [MV_W:0]     w_prev_up;
    logic [MV_W:0]     w_bat_dn;
    logic              w_up;
    logic              w_down;
    logic [DIVW-1:0]   w_dsr;
    logic              w_ge;
    logic [MV_W:0]     w_full_lim;
    logic              w_in_take;
    logic              w_slot_free;
    logic              w_is_emit;
    logic              w_due;
    logic              w_emit_go;
    t_kind             w_kind;
    logic [MV_W-1:0]   w_mv;
    logic [PCT_W-1:0]  w_pct;
    logic              w_last;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (i_uword.op == UOP_LOAD);
    assign w_in_take   = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_ovalid || i_m_tready;

    // Scaling: 12x12 product, upper 16 bits never exceed 65504 so no clip
    assign w_prod = {{RATIO_W{1'b0}}, r_sample} * {{SAMPLE_W{1'b0}}, r_ratio};

    // Jump detection compares
    assign w_prev_up = {1'b0, r_prev_bat} + {1'b0, JUMP_MV};
    assign w_bat_dn  = {1'b0, r_bat} + {1'b0, JUMP_MV};
    assign w_up      = {1'b0, r_bat} > w_prev_up;
    assign w_down    = w_bat_dn <= {1'b0, r_prev_bat};

    // Restoring divider trial
    assign w_dsr = {{PCT_W{1'b0}}, r_den} << r_cnt;
    assign w_ge  = r_rem >= w_dsr;

    assign w_full_lim = {1'b0, r_full_mv} + {1'b0, FULL_MARGIN_MV};

    // Select the result for the current emit step
    always_comb begin
        w_is_emit = 1'b1;
        w_due     = 1'b0;
        w_kind    = KIND_REPORT;
        w_mv      = r_bat;
        w_pct     = r_pct;
        w_last    = 1'b0;
        unique case (i_uword.op)
            UOP_EMIT_CHG: begin
                w_due  = r_chg_ev;
                w_kind = r_chg_stop ? KIND_STOP : KIND_BEGIN;
                w_mv   = r_chg_mv;
                w_pct  = '0;
            end
            UOP_EMIT_RPT: begin
                w_due  = 1'b1;
                w_last = !r_low && !r_full;
            end
            UOP_EMIT_LOW: begin
                w_due  = r_low;
                w_kind = KIND_LOW;
                w_last = !r_full;
            end
            UOP_EMIT_FULL: begin
                w_due  = r_full;
                w_kind = KIND_FULL;
                w_last = 1'b1;
            end
            default: w_is_emit = 1'b0;
        endcase
    end

    assign w_emit_go = w_is_emit && w_due && w_slot_free;

    assign o_status.in_take   = w_in_take;
    assign o_status.emit_go   = w_emit_go;
    assign o_status.emit_skip = w_is_emit && !w_due;
    assign o_status.cnt_zero  = (r_cnt == '0);

    // Configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_pin <= RST_USE_PIN;
            r_ratio   <= RST_RATIO;
            r_empty   <= RST_EMPTY;
            r_full_mv <= RST_FULL;
            r_low_pct <= RST_LOW_PCT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_USE_PIN: r_use_pin <= i_cfg_data[0];
                CFG_RATIO:   r_ratio   <= i_cfg_data[RATIO_W-1:0];
                CFG_EMPTY:   r_empty   <= i_cfg_data;
                CFG_FULL:    r_full_mv <= i_cfg_data;
                CFG_LOW_PCT: r_low_pct <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Charge tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_charging <= 1'b0;
            r_prev_pin <= 1'b0;
            r_prev_bat <= '0;
        end else if (i_uword.op == UOP_CHARGE) begin
            r_started  <= 1'b1;
            r_prev_bat <= r_bat;
            if (r_use_pin) begin
                r_charging <= r_pin;
                r_prev_pin <= r_pin;
            end else if (w_up) begin
                r_charging <= 1'b1;
            end else if (w_down) begin
                r_charging <= 1'b0;
            end
        end
    end

    // Per-sample datapath steps
    always_ff @(posedge i_clk) begin
        case (i_uword.op)
            UOP_LOAD: begin
                if (w_in_take) begin
                    r_sample <= i_s_tdata[SAMPLE_W-1:0];
                    r_pin    <= i_s_tdata[SAMPLE_W];
                end
            end
            UOP_SCALE: begin
                r_bat <= w_prod[PROD_W-1:PROD_W-MV_W];
            end
            UOP_CHARGE: begin
                // Charge event: first pin sample, pin edge, or voltage jump
                r_chg_mv   <= (r_use_pin && !r_started) ? {MV_W{1'b0}} : r_bat;
                r_chg_stop <= r_use_pin ? (r_started && !r_pin) : !w_up;
                if (r_use_pin) begin
                    r_chg_ev <= r_started ? (r_pin != r_prev_pin) : r_pin;
                end else begin
                    r_chg_ev <= w_up ? !r_charging : (w_down && r_charging);
                end
                // Percentage setup; with bat above empty, num >= den iff bat >= full
                r_zero <= (r_full_mv <= r_empty) || (r_bat <= r_empty);
                r_sat  <= r_bat >= r_full_mv;
                r_num  <= r_bat - r_empty;
                r_den  <= r_full_mv - r_empty;
            end
            UOP_PREP: begin
                r_dvd   <= {{PCT_W{1'b0}}, r_num} * {{MV_W{1'b0}}, PCT_FULL};
                r_rem   <= {{PCT_W{1'b0}}, r_num} * {{MV_W{1'b0}}, PCT_FULL};
                r_lprod <= {{PCT_W{1'b0}}, r_den} * {{MV_W{1'b0}}, r_low_pct};
                r_quo   <= '0;
                r_cnt   <= QBIT_TOP;
            end
            UOP_DIV: begin
                // One quotient bit per step, top bit first
                if (w_ge) begin
                    r_rem        <= r_rem - w_dsr;
                    r_quo[r_cnt] <= 1'b1;
                end
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            UOP_FINISH: begin
                if (r_zero) begin
                    r_pct <= '0;
                    r_low <= 1'b1;
                end else if (r_sat) begin
                    r_pct <= PCT_FULL;
                    r_low <= r_low_pct >= PCT_FULL;
                end else begin
                    r_pct <= r_quo;
                    r_low <= r_dvd <= r_lprod;
                end
                r_full <= r_charging && ({1'b0, r_bat} >= w_full_lim);
            end
            default: ;
        endcase
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit_go) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_go) begin
            r_okind <= w_kind;
            r_omv   <= w_mv;
            r_opct  <= w_pct;
            r_olast <= w_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_opct, r_omv};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

endmodule

[hw/rtl/battery_charge_level_monitor_top.sv]
// ----------------------------------------------------------------------------
// Battery charge level monitor
// Turns converter samples into charge, voltage, low and full events.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: sample_mv[11:0], charger_pin[12], zero pad
// m_axis    out        tdata: battery_mv[15:0], level_percent[22:16], zero pad;
//                      tuser: event_kind; tlast: last_of_sample
// cfg       in         index: register number, data: register value
//
// A sample goes from acceptance to the next ready through scale, charge check,
// setup, 7 divider steps, finish and one step for each of the four possible
// results; an emit step holds while a result waits in the output register.
// Reset restores the register defaults and clears the charge state; no clearing
// pass follows.
// ----------------------------------------------------------------------------
module battery_charge_level_monitor_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // sample_mv[11:0], charger_pin[12]
    input  logic [bclm_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // battery_mv[15:0], level_percent[22:16]
    output logic [bclm_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // event_kind[2:0]
    output logic [bclm_pkg::KIND_W-1:0]      o_m_tuser,
    output logic                             o_m_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bclm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bclm_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import bclm_pkg::*;

    t_uword     w_uword;
    t_dp_status w_status;

    // Program sequencer
    bclm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_uword  (w_uword)
    );

    // Datapath
    bclm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (w_uword),
        .o_status    (w_status),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

[hw/rtl/bclm_checker.sv]
// ----------------------------------------------------------------------------
// Battery charge level monitor port checker
// Watches the top level ports for ordering and payload rules.
// ----------------------------------------------------------------------------
`include "battery_charge_level_monitor_top_assert.svh"

module bclm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [bclm_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input logic [bclm_pkg::KIND_W-1:0]      o_m_tuser,
    input logic                             o_m_tlast
);
    import bclm_pkg::*;

    logic w_chg_kind;
    assign w_chg_kind = (o_m_tuser == KIND_BEGIN) || (o_m_tuser == KIND_STOP);

    // Hold a stalled result
    `BCLM_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled result changed")

    // One sample in work at a time
    `BCLM_ASSERT_NEXT(a_in_busy, i_s_tvalid && o_s_tready, !o_s_tready, "input ready right after a request")

    // A charge event always has a report after it
    `BCLM_ASSERT_SAME(a_chg_not_last, o_m_tvalid && w_chg_kind, !o_m_tlast, "charge event marked last")

    // Charge events carry no percentage
    `BCLM_ASSERT_SAME(a_chg_pct, o_m_tvalid && w_chg_kind, o_m_tdata[22:16] == '0, "charge event with percentage")

    // Percentage stays in range and the pad stays clear
    `BCLM_ASSERT_SAME(a_pct_range, o_m_tvalid, (o_m_tdata[22:16] <= PCT_FULL) && !o_m_tdata[23], "percentage out of range")

endmodule

bind battery_charge_level_monitor_top bclm_checker u_bclm_checker (.*);

[tb/battery_charge_level_monitor_top_test.sv]
// ----------------------------------------------------------------------------
// Battery charge level monitor testbench
// Drives samples and register writes into the monitor and compares every
// result against a cycle-free model of the charge and level logic. A short
// table walks the corner cases, then random walks of the battery voltage run
// under three idle patterns and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_charge_level_monitor_top_test;
    import bclm_pkg::*;

    localparam int CLK_HALF_NS     = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int JUMP_STEP_MV    = 400;
    localparam int CHARGED_OVER_MV = 700;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // One battery event as seen on the output stream
    typedef struct packed {
        t_kind       kind;
        logic [15:0] mv;
        logic [6:0]  pct;
        logic        last;
    } level_evt_t;

    // Directed plan: register writes and samples, some with a known level
    typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_e;
    typedef struct packed {
        row_kind_e             rk;
        logic [CFG_IDX_W-1:0]  idx;
        logic [15:0]           val;
        logic                  pin;
        logic                  typed;
        logic [15:0]           mv;
        logic [6:0]            pct;
    } plan_row_t;

    localparam int PLAN_LEN = 28;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // pin mode from the very first sample: high pin gives a zero begin
        '{ROW_REG,    CFG_USE_PIN,    16'd1,     1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd2100,  1'b1, 1'b1, 16'd4200,  7'd100},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd4095,  1'b1, 1'b1, 16'd8190,  7'd100},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd0,     1'b0, 1'b1, 16'd0,     7'd0},
        // exactly at the low threshold, then just above it
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd1620,  1'b1, 1'b1, 16'd3240,  7'd20},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd1621,  1'b1, 1'b1, 16'd3242,  7'd20},
        // switch to jump detection while running
        '{ROW_REG,    CFG_USE_PIN,    16'd0,     1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd1800,  1'b1, 1'b1, 16'd3600,  7'd50},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd1500,  1'b0, 1'b1, 16'd3000,  7'd0},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd1740,  1'b0, 1'b0, 16'd0,     7'd0},
        // zero divider ratio
        '{ROW_REG,    CFG_RATIO,      16'd0,     1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd4095,  1'b1, 1'b1, 16'd0,     7'd0},
        // largest ratio and sample
        '{ROW_REG,    CFG_RATIO,      16'd4095,  1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd4095,  1'b1, 1'b1, 16'd65504, 7'd100},
        // empty not below full
        '{ROW_REG,    CFG_RATIO,      16'd256,   1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_REG,    CFG_FULL,       16'd3000,  1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd3500,  1'b0, 1'b1, 16'd3500,  7'd0},
        // widest range, low threshold at both ends
        '{ROW_REG,    CFG_EMPTY,      16'd0,     1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_REG,    CFG_FULL,       16'd65535, 1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_REG,    CFG_LOW_PCT,    16'd100,   1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd4095,  1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_REG,    CFG_LOW_PCT,    16'd0,     1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd0,     1'b0, 1'b1, 16'd0,     7'd0},
        // write to an index past the register list, then jump boundaries
        '{ROW_REG,    CFG_UNUSED_IDX, 16'hFFFF,  1'b0, 1'b0, 16'd0,     7'd0},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd2048,  1'b1, 1'b0, 16'd0,     7'd0},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd2448,  1'b0, 1'b1, 16'd2448,  7'd3},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd2048,  1'b0, 1'b1, 16'd2048,  7'd3},
        '{ROW_SAMPLE, CFG_USE_PIN,    16'd2449,  1'b1, 1'b0, 16'd0,     7'd0}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [KIND_W-1:0]    o_m_tuser;
    logic                 o_m_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    // Model copy of the registers
    logic        cfg_use_pin = RST_USE_PIN;
    logic [11:0] cfg_ratio   = 12'd512;
    logic [15:0] cfg_empty   = 16'd3000;
    logic [15:0] cfg_full    = 16'd4200;
    logic [6:0]  cfg_low     = 7'd20;

    // Model copy of the charge state
    bit          mon_started = 1'b0;
    bit          chg_active  = 1'b0;
    bit          pin_level   = 1'b0;
    logic [15:0] prev_bat_mv = '0;

    level_evt_t  expected_evts[$];
    int          fail_count    = 0;
    int          cycles        = 0;
    int          send_idle_pct = 12;
    int          recv_idle_pct = 46;
    int          hold_from     = -1;
    int          walk_sample   = 2048;
    bit          walk_pin      = 1'b0;

    battery_charge_level_monitor_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch %0d: %s", fail_count, msg);
    endfunction

    // Work out the events of one sample and queue them; a typed level
    // replaces the computed voltage and percentage of the level events
    function automatic void predict_sample(input logic [11:0] smp, input logic pin,
                                           input logic typed, input logic [15:0] t_mv,
                                           input logic [6:0] t_pct);
        level_evt_t  evts[4];
        int          n;
        logic [31:0] bat, num, den;
        logic [6:0]  pct;
        logic        is_low;
        n   = 0;
        bat = (32'(smp) * 32'(cfg_ratio)) >> 8;
        if (bat > 32'hFFFF)
            bat = 32'hFFFF;

        // Charge tracking
        if (cfg_use_pin) begin
            if (!mon_started) begin
                pin_level = pin;
                if (pin) begin
                    evts[n] = '{KIND_BEGIN, 16'd0, 7'd0, 1'b0};
                    n++;
                end
            end else if (pin != pin_level) begin
                evts[n] = '{pin ? KIND_BEGIN : KIND_STOP, bat[15:0], 7'd0, 1'b0};
                n++;
                pin_level = pin;
            end
            chg_active = pin;
        end else if (bat > 32'(prev_bat_mv) + JUMP_STEP_MV) begin
            if (!chg_active) begin
                chg_active = 1'b1;
                evts[n] = '{KIND_BEGIN, bat[15:0], 7'd0, 1'b0};
                n++;
            end
        end else if (bat + JUMP_STEP_MV <= 32'(prev_bat_mv) && chg_active) begin
            chg_active = 1'b0;
            evts[n] = '{KIND_STOP, bat[15:0], 7'd0, 1'b0};
            n++;
        end
        mon_started = 1'b1;

        // Level and low test on the exact ratio
        if (cfg_full <= cfg_empty || bat <= 32'(cfg_empty)) begin
            pct    = '0;
            is_low = 1'b1;
        end else begin
            num = bat - 32'(cfg_empty);
            den = 32'(cfg_full) - 32'(cfg_empty);
            if (num >= den) begin
                pct    = 7'd100;
                is_low = (cfg_low >= 7'd100);
            end else begin
                pct    = 7'((num * 100) / den);
                is_low = (num * 100 <= 32'(cfg_low) * den);
            end
        end

        evts[n] = '{KIND_REPORT, bat[15:0], pct, 1'b0};
        n++;
        if (is_low) begin
            evts[n] = '{KIND_LOW, bat[15:0], pct, 1'b0};
            n++;
        end
        if (chg_active && bat >= 32'(cfg_full) + CHARGED_OVER_MV) begin
            evts[n] = '{KIND_FULL, bat[15:0], pct, 1'b0};
            n++;
        end
        evts[n-1].last = 1'b1;
        prev_bat_mv = bat[15:0];

        for (int i = 0; i < n; i++) begin
            if (typed && evts[i].kind != KIND_BEGIN && evts[i].kind != KIND_STOP) begin
                evts[i].mv  = t_mv;
                evts[i].pct = t_pct;
            end
            expected_evts.push_back(evts[i]);
        end
    endfunction

    // Drive output ready; hold it low for a long stretch once requested
    always @(negedge i_clk) begin
        if (hold_from >= 0 && cycles - hold_from < RX_HOLD_CYCLES)
            i_m_tready = 1'b0;
        else
            i_m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest expected event
    always @(posedge i_clk) begin
        level_evt_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_evts.size() == 0) begin
                note_failure($sformatf("unexpected kind=%0d mv=%0d pct=%0d last=%0b",
                                       o_m_tuser, o_m_tdata[15:0], o_m_tdata[22:16],
                                       o_m_tlast));
            end else begin
                want = expected_evts.pop_front();
                if (o_m_tuser != want.kind || o_m_tdata[15:0] != want.mv ||
                    o_m_tdata[22:16] != want.pct || o_m_tlast != want.last)
                    note_failure($sformatf(
                        "exp kind=%0d mv=%0d pct=%0d last=%0b, got kind=%0d mv=%0d pct=%0d last=%0b",
                        want.kind, want.mv, want.pct, want.last, o_m_tuser,
                        o_m_tdata[15:0], o_m_tdata[22:16], o_m_tlast));
            end
        end
    end

    // Offer one sample request, idling at random first; starts and ends at a falling edge
    task automatic send_sample(input logic [11:0] smp, input logic pin, input logic typed,
                               input logic [15:0] t_mv, input logic [6:0] t_pct);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            i_s_tdata  = 16'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {3'b000, pin, smp};
        do @(posedge i_clk); while (!o_s_tready);
        predict_sample(smp, pin, typed, t_mv, t_pct);
        @(negedge i_clk);
    endtask

    // Drop the sample request and wait until every event has drained
    task automatic wait_idle();
        i_s_tvalid = 1'b0;
        while (expected_evts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_USE_PIN: cfg_use_pin = val[0];
            CFG_RATIO:   cfg_ratio   = val[11:0];
            CFG_EMPTY:   cfg_empty   = val;
            CFG_FULL:    cfg_full    = val;
            CFG_LOW_PCT: cfg_low     = val[6:0];
            default:     ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random walk of the tap voltage: mostly drift, some charge-sized jumps,
    // a few rail values and unrelated readings
    task automatic send_random(input int count);
        int pick, step;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                walk_sample = $urandom_range(1) ? 4095 : 0;
            end else if (pick < 16) begin
                walk_sample = $urandom_range(4095);
            end else if (pick < 40) begin
                step = $urandom_range(900, 200);
                walk_sample += $urandom_range(1) ? step : -step;
            end else begin
                walk_sample += int'($urandom_range(60)) - 30;
            end
            if (walk_sample < 0)
                walk_sample = 0;
            if (walk_sample > 4095)
                walk_sample = 4095;
            if ($urandom_range(99) < 15)
                walk_pin = ~walk_pin;
            send_sample(12'(walk_sample), walk_pin, 1'b0, 16'd0, 7'd0);
        end
    endtask

    task automatic load_regs(input logic use_pin, input logic [11:0] ratio,
                             input logic [15:0] empty_v, input logic [15:0] full_v,
                             input logic [6:0] low_v);
        write_reg(CFG_USE_PIN, {15'd0, use_pin});
        write_reg(CFG_RATIO,   {4'd0, ratio});
        write_reg(CFG_EMPTY,   empty_v);
        write_reg(CFG_FULL,    full_v);
        write_reg(CFG_LOW_PCT, {9'd0, low_v});
    endtask

    initial begin
        logic [15:0] lo_mv;
        // Hold reset at the start, then release it
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed table
        for (int r = 0; r < PLAN_LEN; r++) begin
            if (PLAN[r].rk == ROW_REG) begin
                wait_idle();
                write_reg(PLAN[r].idx, PLAN[r].val);
            end else begin
                send_sample(PLAN[r].val[11:0], PLAN[r].pin, PLAN[r].typed,
                            PLAN[r].mv, PLAN[r].pct);
            end
        end

        // Jump detection at the default range
        wait_idle();
        load_regs(1'b0, 12'd512, 16'd3000, 16'd4200, 7'd20);
        send_random(120);

        // Pin mode, random range, swapped idling and one long output stall
        wait_idle();
        lo_mv = 16'($urandom_range(4000, 2000));
        load_regs(1'b1, 12'($urandom_range(1200, 200)), lo_mv,
                  lo_mv + 16'($urandom_range(3000, 100)), 7'($urandom_range(100)));
        send_idle_pct = 46;
        recv_idle_pct = 12;
        send_random(20);
        hold_from = cycles;
        send_random(100);

        // Jump detection, random register values, no idling
        wait_idle();
        load_regs(1'b0, 12'($urandom_range(4095, 1)), 16'($urandom), 16'($urandom),
                  7'($urandom_range(100)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(110);

        wait_idle();
        if (expected_evts.size() != 0)
            note_failure($sformatf("%0d events never arrived", expected_evts.size()));
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
